@@ rtl/core/vertex_rotate_project_defines.svh @@
// Assertion macros for the vertex rotate and project core
`ifndef VERTEX_ROTATE_PROJECT_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_DEFINES_SVH

`ifndef ASSERT_OFF

// pre holds -> post holds in the same cycle
`define VRP_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("vertex_rotate_project: assertion failed");

// pre holds -> post holds in the next cycle
`define VRP_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("vertex_rotate_project: assertion failed");

`else

`define VRP_ASSERT_NOW(label, clk, rst, pre, post)
`define VRP_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

@@ rtl/core/vrp_pkg.sv @@
// Types, constants and helper functions for the vertex rotate and project core
package vrp_pkg;

   localparam int TRIG_FRAC    = 14;
   localparam int TRIG_W       = 16;
   localparam int ROM_W        = 15;
   localparam int COORD_W      = 16;
   localparam int ROT_W        = 18;
   localparam int SCREEN_W     = 12;
   localparam int QUOT_W       = 13;
   localparam int CFG_ANGLE_W  = 16;
   localparam int CFG_W        = 10;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam logic [CFG_W-1:0] FOCAL_RESET  = 10'd240;
   localparam logic [CFG_W-1:0] EYE_RESET    = 10'd150;
   localparam logic [CFG_W-1:0] CENTER_RESET = 10'd120;

   localparam logic [CFG_ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

   localparam logic signed [SCREEN_W-1:0] SCREEN_MAX = 12'sd2047;
   localparam logic signed [SCREEN_W-1:0] SCREEN_MIN = -12'sd2048;
   localparam logic [QUOT_W-1:0] POS_LIMIT = 13'd2047;
   localparam logic [QUOT_W-1:0] NEG_LIMIT = 13'd2048;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ANGLE_X     = 3'd0,
      REG_ANGLE_Y     = 3'd1,
      REG_FOCAL_SCALE = 3'd2,
      REG_EYE_OFFSET  = 3'd3,
      REG_CENTER_X    = 3'd4,
      REG_CENTER_Y    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [SCREEN_W-1:0] value;
      logic                       clip;
   } screen_type;

   // Quarter-wave sine entry k in Q14, Q30 Taylor series; elaboration only
   function automatic logic [ROM_W-1:0] sine_entry(input int unsigned k,
                                                   input int unsigned bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] prod;
      logic signed [63:0] sum;
      x    = (HALF_PI_Q30 * 64'(k)) >> bits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 12; n++) begin
         prod = (term * x2) >> 30;
         case (n)
            1:  term = prod / 64'd6;
            2:  term = prod / 64'd20;
            3:  term = prod / 64'd42;
            4:  term = prod / 64'd72;
            5:  term = prod / 64'd110;
            6:  term = prod / 64'd156;
            7:  term = prod / 64'd210;
            8:  term = prod / 64'd272;
            9:  term = prod / 64'd342;
            10: term = prod / 64'd420;
            11: term = prod / 64'd506;
            default: term = prod / 64'd600;
         endcase
         if ((n % 2) == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > (64'sd1 <<< 30)) begin
         sum = 64'sd1 <<< 30;
      end
      sum = (sum + (64'sd1 <<< 15)) >>> 16;
      if (sum > 64'sd16384) begin
         sum = 64'sd16384;
      end
      return ROM_W'(sum);
   endfunction

   // Saturation of one projected coordinate from quotient magnitude and signs
   function automatic screen_type sat_coord(input logic [QUOT_W-1:0] q,
                                            input logic neg, input logic sgn,
                                            input logic dpos);
      screen_type s;
      s.clip  = 1'b0;
      s.value = SCREEN_W'(q);
      if (!dpos) begin
         s.clip  = 1'b1;
         s.value = sgn ? SCREEN_MIN : SCREEN_MAX;
      end else if (!neg) begin
         if (q > POS_LIMIT) begin
            s.clip  = 1'b1;
            s.value = SCREEN_MAX;
         end
      end else begin
         if (q > NEG_LIMIT) begin
            s.clip  = 1'b1;
            s.value = SCREEN_MIN;
         end else begin
            s.value = SCREEN_W'(-$signed({1'b0, q}));
         end
      end
      return s;
   endfunction

endpackage

@@ rtl/core/vertex_rotate_project.sv @@
// Vertex rotation about X then Y with perspective projection, fully pipelined
//
//   channel  direction  ports                                      transfer when
//   req      in         req_vertex_x/y/z                           req_valid & req_ready
//   rsp      out        rsp_screen_x/y, rsp_clipped                rsp_valid & rsp_ready
//   csr      in         csr_index, csr_wdata                       csr_valid & csr_ready
//
// One vertex per cycle while rsp is not stalled and no table load runs; stages: rotation 4,
// projection products 2, magnitude 1, 13-bit restoring divider at 2 bits a stage 7, saturation 1.
// After reset and after each angle write a sine table load refreshes the trig
// registers; req_ready is low meanwhile.
// Stages hand on independently: bubbles close up while rsp is stalled.
`include "vertex_rotate_project_defines.svh"

module vertex_rotate_project #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int COORD_FRAC_BITS = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [vrp_pkg::COORD_W-1:0]       req_vertex_x,
   input  logic signed [vrp_pkg::COORD_W-1:0]       req_vertex_y,
   input  logic signed [vrp_pkg::COORD_W-1:0]       req_vertex_z,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [vrp_pkg::SCREEN_W-1:0]      rsp_screen_x,
   output logic signed [vrp_pkg::SCREEN_W-1:0]      rsp_screen_y,
   output logic                                     rsp_clipped,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [vrp_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  logic [vrp_pkg::CSR_DATA_W-1:0]           csr_wdata
);

   localparam int TAB_N = 1 << SINE_TABLE_BITS;
   localparam int AW    = SINE_TABLE_BITS + 1;
   localparam int RW    = vrp_pkg::ROT_W;
   localparam int DW    = ((RW > 11 + COORD_FRAC_BITS) ? RW : 11 + COORD_FRAC_BITS) + 1;
   localparam int NW    = DW + 12;
   localparam int QW    = vrp_pkg::QUOT_W;
   localparam int DS    = (QW + 1) / 2;
   localparam int NS    = 8 + DS;
   localparam int TF    = vrp_pkg::TRIG_FRAC;

   typedef struct packed {
      logic [DW-1:0] denom;
      logic          dpos;
      logic          neg_x;
      logic          neg_y;
      logic          sgn_x;
      logic          sgn_y;
   } side_type;

   // ---------------------------------------------------------------- config
   logic [vrp_pkg::CFG_ANGLE_W-1:0] angle_x_ff, angle_y_ff;
   logic [vrp_pkg::CFG_W-1:0]       focal_scale_ff, eye_offset_ff, center_x_ff, center_y_ff;
   logic                            csr_fire;
   logic                            angle_write;

   assign csr_ready   = 1'b1;
   assign csr_fire    = csr_valid && csr_ready;
   assign angle_write = csr_fire &&
                        (vrp_pkg::csr_index_type'(csr_index) == vrp_pkg::REG_ANGLE_X ||
                         vrp_pkg::csr_index_type'(csr_index) == vrp_pkg::REG_ANGLE_Y);

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_x_ff     <= '0;
         angle_y_ff     <= '0;
         focal_scale_ff <= vrp_pkg::FOCAL_RESET;
         eye_offset_ff  <= vrp_pkg::EYE_RESET;
         center_x_ff    <= vrp_pkg::CENTER_RESET;
         center_y_ff    <= vrp_pkg::CENTER_RESET;
      end else if (csr_fire) begin
         case (vrp_pkg::csr_index_type'(csr_index))
            vrp_pkg::REG_ANGLE_X:     angle_x_ff     <= csr_wdata;
            vrp_pkg::REG_ANGLE_Y:     angle_y_ff     <= csr_wdata;
            vrp_pkg::REG_FOCAL_SCALE: focal_scale_ff <= csr_wdata[vrp_pkg::CFG_W-1:0];
            vrp_pkg::REG_EYE_OFFSET:  eye_offset_ff  <= csr_wdata[vrp_pkg::CFG_W-1:0];
            vrp_pkg::REG_CENTER_X:    center_x_ff    <= csr_wdata[vrp_pkg::CFG_W-1:0];
            vrp_pkg::REG_CENTER_Y:    center_y_ff    <= csr_wdata[vrp_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- sine table load
   logic [vrp_pkg::ROM_W-1:0] sine_rom [0:TAB_N];

   for (genvar k = 0; k <= TAB_N; k++) begin : g_rom
      assign sine_rom[k] = vrp_pkg::sine_entry(k, SINE_TABLE_BITS);
   end

   logic                              trig_busy_ff, trig_busy_in;
   logic [1:0]                        trig_step_ff, trig_step_in;
   logic                              rd_valid_ff;
   logic [1:0]                        rd_step_ff;
   logic                              rd_neg_ff;
   logic [vrp_pkg::ROM_W-1:0]         rom_q_ff;
   logic [vrp_pkg::CFG_ANGLE_W-1:0]   phase;
   logic [SINE_TABLE_BITS-1:0]        tab_idx;
   logic [AW-1:0]                     rom_addr;
   logic signed [vrp_pkg::TRIG_W-1:0] trig_ff [4];
   logic signed [vrp_pkg::TRIG_W-1:0] sin_x, cos_x, sin_y, cos_y;

   // step 0 sin(ax), 1 cos(ax), 2 sin(ay), 3 cos(ay)
   always_comb begin
      phase    = (trig_step_ff[1] ? angle_y_ff : angle_x_ff) +
                 (trig_step_ff[0] ? vrp_pkg::QUARTER_TURN : '0);
      tab_idx  = phase[13 -: SINE_TABLE_BITS];
      rom_addr = phase[14] ? AW'(TAB_N) - AW'(tab_idx) : AW'(tab_idx);
   end

   always_comb begin
      trig_busy_in = trig_busy_ff;
      trig_step_in = trig_step_ff;
      if (angle_write) begin
         trig_busy_in = 1'b1;
         trig_step_in = '0;
      end else if (trig_busy_ff) begin
         trig_step_in = trig_step_ff + 2'd1;
         if (trig_step_ff == 2'd3) begin
            trig_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_busy_ff <= 1'b1;
         trig_step_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         trig_busy_ff <= trig_busy_in;
         trig_step_ff <= trig_step_in;
         rd_valid_ff  <= trig_busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_step_ff <= trig_step_ff;
      rd_neg_ff  <= phase[15];
      rom_q_ff   <= sine_rom[rom_addr];
      if (rd_valid_ff) begin
         trig_ff[rd_step_ff] <= rd_neg_ff ? -$signed({1'b0, rom_q_ff})
                                          :  $signed({1'b0, rom_q_ff});
      end
   end

   assign sin_x = trig_ff[0];
   assign cos_x = trig_ff[1];
   assign sin_y = trig_ff[2];
   assign cos_y = trig_ff[3];

   // ------------------------------------------------------------ stage control
   logic [NS:1]   v_ff;
   logic [NS+1:1] en;
   logic          req_fire;

   always_comb begin
      en[NS+1] = rsp_ready;
      for (int k = NS; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[1] && !trig_busy_ff && !rd_valid_ff;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[1]) begin
            v_ff[1] <= req_fire;
         end
         for (int k = 2; k <= NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // ---------------------------------------------------- rotation about X
   logic signed [31:0] s1_yc_ff, s1_zs_ff, s1_ys_ff, s1_zc_ff;
   logic signed [vrp_pkg::COORD_W-1:0] s1_x_ff, s2_x_ff;
   logic signed [RW-1:0] s2_ny_ff, s2_nz_ff, s2_ny_in, s2_nz_in;
   logic signed [32:0] s2_a, s2_b;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_yc_ff <= 32'(req_vertex_y) * 32'(cos_x);
         s1_zs_ff <= 32'(req_vertex_z) * 32'(sin_x);
         s1_ys_ff <= 32'(req_vertex_y) * 32'(sin_x);
         s1_zc_ff <= 32'(req_vertex_z) * 32'(cos_x);
         s1_x_ff  <= req_vertex_x;
      end
   end

   always_comb begin
      s2_a     = 33'(s1_yc_ff) - 33'(s1_zs_ff);
      s2_b     = 33'(s1_ys_ff) + 33'(s1_zc_ff);
      s2_ny_in = RW'(s2_a >>> TF);
      s2_nz_in = RW'(s2_b >>> TF);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_ny_ff <= s2_ny_in;
         s2_nz_ff <= s2_nz_in;
         s2_x_ff  <= s1_x_ff;
      end
   end

   // ---------------------------------------------------- rotation about Y
   logic signed [33:0] s3_xc_ff, s3_ns_ff, s3_xs_ff, s3_nc_ff;
   logic signed [RW-1:0] s3_ny_ff;
   logic signed [34:0] s4_a, s4_b;
   logic signed [RW-1:0] s4_nz2;
   logic signed [RW-1:0] s4_nx_ff, s4_ny_ff, s4_nx_in;
   logic signed [DW-1:0] s4_denom_ff, s4_denom_in, eye_ext;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_xc_ff <= 34'(s2_x_ff) * 34'(cos_y);
         s3_xs_ff <= 34'(s2_x_ff) * 34'(sin_y);
         s3_ns_ff <= 34'(s2_nz_ff) * 34'(sin_y);
         s3_nc_ff <= 34'(s2_nz_ff) * 34'(cos_y);
         s3_ny_ff <= s2_ny_ff;
      end
   end

   always_comb begin
      s4_a        = 35'(s3_xc_ff) - 35'(s3_ns_ff);
      s4_b        = 35'(s3_xs_ff) + 35'(s3_nc_ff);
      s4_nx_in    = RW'(s4_a >>> TF);
      s4_nz2      = RW'(s4_b >>> TF);
      eye_ext     = $signed({{(DW - vrp_pkg::CFG_W){1'b0}}, eye_offset_ff});
      s4_denom_in = DW'(s4_nz2) + (eye_ext <<< COORD_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_nx_ff    <= s4_nx_in;
         s4_ny_ff    <= s3_ny_ff;
         s4_denom_ff <= s4_denom_in;
      end
   end

   // ------------------------------------------------ projection numerators
   logic signed [NW-1:0] s5_mx_ff, s5_my_ff, s5_cx_ff, s5_cy_ff;
   logic signed [DW-1:0] s5_denom_ff;
   logic                 s5_sgn_x_ff, s5_sgn_y_ff;
   logic signed [NW-1:0] s6_num_x_ff, s6_num_y_ff;
   side_type             s6_side_ff;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_mx_ff    <= NW'(s4_nx_ff) * NW'($signed({1'b0, focal_scale_ff}));
         s5_my_ff    <= NW'(s4_ny_ff) * NW'($signed({1'b0, focal_scale_ff}));
         s5_cx_ff    <= NW'($signed({1'b0, center_x_ff})) * NW'(s4_denom_ff);
         s5_cy_ff    <= NW'($signed({1'b0, center_y_ff})) * NW'(s4_denom_ff);
         s5_denom_ff <= s4_denom_ff;
         s5_sgn_x_ff <= s4_nx_ff[RW-1];
         s5_sgn_y_ff <= s4_ny_ff[RW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s6_num_x_ff      <= s5_mx_ff + s5_cx_ff;
         s6_num_y_ff      <= s5_my_ff + s5_cy_ff;
         s6_side_ff.denom <= s5_denom_ff;
         s6_side_ff.dpos  <= (s5_denom_ff > 0);
         s6_side_ff.sgn_x <= s5_sgn_x_ff;
         s6_side_ff.sgn_y <= s5_sgn_y_ff;
         s6_side_ff.neg_x <= 1'b0;
         s6_side_ff.neg_y <= 1'b0;
      end
   end

   // ------------------------------------------ magnitude, then divider stages
   logic [NW-1:0] dr_x_ff [0:DS];
   logic [NW-1:0] dr_y_ff [0:DS];
   logic [QW-1:0] dq_x_ff [0:DS];
   logic [QW-1:0] dq_y_ff [0:DS];
   side_type      dside_ff [0:DS];

   always_ff @(posedge clock) begin
      if (en[7]) begin
         dr_x_ff[0]  <= s6_num_x_ff[NW-1] ? NW'(-s6_num_x_ff) : NW'(s6_num_x_ff);
         dr_y_ff[0]  <= s6_num_y_ff[NW-1] ? NW'(-s6_num_y_ff) : NW'(s6_num_y_ff);
         dq_x_ff[0]  <= '0;
         dq_y_ff[0]  <= '0;
         dside_ff[0] <= '{denom: s6_side_ff.denom, dpos: s6_side_ff.dpos,
                          neg_x: s6_num_x_ff[NW-1], neg_y: s6_num_y_ff[NW-1],
                          sgn_x: s6_side_ff.sgn_x, sgn_y: s6_side_ff.sgn_y};
      end
   end

   // restoring division, two quotient bits a stage, top bit flags overflow
   for (genvar j = 0; j < DS; j++) begin : g_div
      localparam int BHI = QW - 1 - 2 * j;
      localparam int BLO = BHI - 1;
      logic [NW-1:0] d;
      logic [NW-1:0] rx, ry;
      logic [QW-1:0] qx, qy;

      always_comb begin
         d  = NW'(dside_ff[j].denom);
         rx = dr_x_ff[j];
         ry = dr_y_ff[j];
         qx = dq_x_ff[j];
         qy = dq_y_ff[j];
         if ((rx >> BHI) >= d) begin
            rx      = rx - (d << BHI);
            qx[BHI] = 1'b1;
         end
         if ((ry >> BHI) >= d) begin
            ry      = ry - (d << BHI);
            qy[BHI] = 1'b1;
         end
         if (BLO >= 0) begin
            if ((rx >> BLO) >= d) begin
               rx                  = rx - (d << BLO);
               qx[(BLO >= 0) ? BLO : 0] = 1'b1;
            end
            if ((ry >> BLO) >= d) begin
               ry                  = ry - (d << BLO);
               qy[(BLO >= 0) ? BLO : 0] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[8 + j]) begin
            dr_x_ff[j+1]  <= rx;
            dr_y_ff[j+1]  <= ry;
            dq_x_ff[j+1]  <= qx;
            dq_y_ff[j+1]  <= qy;
            dside_ff[j+1] <= dside_ff[j];
         end
      end
   end

   // ---------------------------------------------------------- saturation
   vrp_pkg::screen_type sat_x, sat_y;
   logic signed [vrp_pkg::SCREEN_W-1:0] rsp_screen_x_ff, rsp_screen_y_ff;
   logic                                rsp_clipped_ff;

   always_comb begin
      sat_x = vrp_pkg::sat_coord(dq_x_ff[DS], dside_ff[DS].neg_x, dside_ff[DS].sgn_x,
                                 dside_ff[DS].dpos);
      sat_y = vrp_pkg::sat_coord(dq_y_ff[DS], dside_ff[DS].neg_y, dside_ff[DS].sgn_y,
                                 dside_ff[DS].dpos);
   end

   always_ff @(posedge clock) begin
      if (en[NS]) begin
         rsp_screen_x_ff <= sat_x.value;
         rsp_screen_y_ff <= sat_y.value;
         rsp_clipped_ff  <= sat_x.clip || sat_y.clip;
      end
   end

   assign rsp_valid    = v_ff[NS];
   assign rsp_screen_x = rsp_screen_x_ff;
   assign rsp_screen_y = rsp_screen_y_ff;
   assign rsp_clipped  = rsp_clipped_ff;

   // ---------------------------------------------------------- assertions
   `VRP_ASSERT_NEXT(a_angle_write_reloads, clock, reset, angle_write, trig_busy_ff)
   `VRP_ASSERT_NEXT(a_rom_read_follows, clock, reset, trig_busy_ff, rd_valid_ff)
   `VRP_ASSERT_NEXT(a_blocked_stage_holds, clock, reset, v_ff[1] && !en[2], v_ff[1])
   `VRP_ASSERT_NEXT(a_no_depth_clips, clock, reset,
                    v_ff[NS-1] && en[NS] && !dside_ff[DS].dpos, rsp_clipped)

endmodule
